// ===== src/tbsc_pkg.sv =====
// shared types, format codes and helper functions for the texture buffer size calculator
package tbsc_pkg;

    // field widths
    localparam int SIDE_W       = 11;
    localparam int FMT_W        = 6;
    localparam int LEVEL_W      = 8;
    localparam int OUT_W        = 24;
    localparam int PROD_W       = 2 * SIDE_W;
    localparam int ACC_W        = PROD_W + 7;
    localparam int IN_FIELDS_W  = 2 * SIDE_W + FMT_W + 1 + LEVEL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

    // an 11-bit side halves to 1 in at most this many levels
    localparam int LEVEL_STAGES = SIDE_W;

    // tile shift width and rounding mask width
    localparam int SHIFT_W      = 2;
    localparam int MASK_W       = 4;

    localparam logic [OUT_W-1:0] SIZE_SAT = {OUT_W{1'b1}};

    // format codes
    localparam logic [FMT_W-1:0] FMT_I4     = 6'h00;
    localparam logic [FMT_W-1:0] FMT_I8     = 6'h01;
    localparam logic [FMT_W-1:0] FMT_IA4    = 6'h02;
    localparam logic [FMT_W-1:0] FMT_IA8    = 6'h03;
    localparam logic [FMT_W-1:0] FMT_RGB565 = 6'h04;
    localparam logic [FMT_W-1:0] FMT_RGB5A3 = 6'h05;
    localparam logic [FMT_W-1:0] FMT_RGBA8  = 6'h06;
    localparam logic [FMT_W-1:0] FMT_C4     = 6'h08;
    localparam logic [FMT_W-1:0] FMT_C8     = 6'h09;
    localparam logic [FMT_W-1:0] FMT_C14X2  = 6'h0A;
    localparam logic [FMT_W-1:0] FMT_CMPR   = 6'h0E;
    localparam logic [FMT_W-1:0] FMT_Z8     = 6'h11;
    localparam logic [FMT_W-1:0] FMT_Z16    = 6'h13;
    localparam logic [FMT_W-1:0] FMT_Z24X8  = 6'h16;
    localparam logic [FMT_W-1:0] FMT_R4     = 6'h20;
    localparam logic [FMT_W-1:0] FMT_RA4    = 6'h22;
    localparam logic [FMT_W-1:0] FMT_RA8    = 6'h23;
    localparam logic [FMT_W-1:0] FMT_A8     = 6'h27;
    localparam logic [FMT_W-1:0] FMT_R8     = 6'h28;
    localparam logic [FMT_W-1:0] FMT_G8     = 6'h29;
    localparam logic [FMT_W-1:0] FMT_B8     = 6'h2A;
    localparam logic [FMT_W-1:0] FMT_RG8    = 6'h2B;
    localparam logic [FMT_W-1:0] FMT_GB8    = 6'h2C;
    localparam logic [FMT_W-1:0] FMT_Z4     = 6'h30;
    localparam logic [FMT_W-1:0] FMT_Z8M    = 6'h39;
    localparam logic [FMT_W-1:0] FMT_Z8L    = 6'h3A;
    localparam logic [FMT_W-1:0] FMT_Z16L   = 6'h3C;

    // tile geometry of one format
    typedef struct packed {
        logic [SHIFT_W-1:0] sx;
        logic [SHIFT_W-1:0] sy;
        logic               tb64;
    } t_tile;

    // payload carried down the level pipeline
    typedef struct packed {
        logic [SIDE_W-1:0]  w;
        logic [SIDE_W-1:0]  h;
        t_tile              tile;
        logic [LEVEL_W-1:0] levels;
        logic               done;
        logic [PROD_W-1:0]  prod;
        logic [ACC_W-1:0]   total;
    } t_stage;

    // tile size lookup; I4 and unknown codes fall to 1x1
    function automatic t_tile tile_decode(input logic [FMT_W-1:0] fmt);
        t_tile t;
        t.tb64 = (fmt == FMT_RGBA8) || (fmt == FMT_Z24X8);
        unique case (fmt)
            FMT_C4, FMT_C8, FMT_C14X2, FMT_CMPR, FMT_R4, FMT_Z4: begin
                t.sx = 2'd3;
                t.sy = 2'd3;
            end
            FMT_I8, FMT_IA4, FMT_Z8, FMT_RA4, FMT_A8,
            FMT_R8, FMT_G8, FMT_B8, FMT_Z8M, FMT_Z8L: begin
                t.sx = 2'd3;
                t.sy = 2'd2;
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8, FMT_Z16,
            FMT_Z24X8, FMT_RA8, FMT_RG8, FMT_GB8, FMT_Z16L: begin
                t.sx = 2'd2;
                t.sy = 2'd2;
            end
            default: begin
                t.sx = 2'd0;
                t.sy = 2'd0;
            end
        endcase
        return t;
    endfunction

    // tile count to bytes: 64 or 32 bytes a tile
    function automatic logic [ACC_W-1:0] tiles_to_bytes(input logic [PROD_W-1:0] prod,
                                                        input logic tb64);
        logic [ACC_W-1:0] p;
        p = ACC_W'(prod);
        return tb64 ? (p << 6) : (p << 5);
    endfunction

endpackage

// ===== src/tbsc_level.sv =====
// one mip level stage: tile count of this level, running sum of the previous one
module tbsc_level
    import tbsc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_stage o_stage
);

    logic                 r_valid;
    t_stage               r_stage;
    t_stage               n_stage;

    logic                 live;
    logic [MASK_W-1:0]    mask_x;
    logic [MASK_W-1:0]    mask_y;
    logic [SIDE_W:0]      sum_x;
    logic [SIDE_W:0]      sum_y;
    logic [SIDE_W:0]      tiles_x;
    logic [SIDE_W:0]      tiles_y;

    // round each side up to whole tiles
    always_comb begin
        mask_x  = (MASK_W'(1) << i_stage.tile.sx) - MASK_W'(1);
        mask_y  = (MASK_W'(1) << i_stage.tile.sy) - MASK_W'(1);
        sum_x   = {1'b0, i_stage.w} + {{(SIDE_W + 1 - MASK_W){1'b0}}, mask_x};
        sum_y   = {1'b0, i_stage.h} + {{(SIDE_W + 1 - MASK_W){1'b0}}, mask_y};
        tiles_x = sum_x >> i_stage.tile.sx;
        tiles_y = sum_y >> i_stage.tile.sy;
    end

    // level product, halving and running total
    always_comb begin
        live            = (i_stage.levels != '0) && !i_stage.done;
        n_stage         = i_stage;
        n_stage.total   = i_stage.total + tiles_to_bytes(i_stage.prod, i_stage.tile.tb64);
        n_stage.prod    = '0;
        if (live) begin
            n_stage.prod   = PROD_W'(tiles_x[SIDE_W-1:0]) * PROD_W'(tiles_y[SIDE_W-1:0]);
            n_stage.levels = i_stage.levels - LEVEL_W'(1);
            n_stage.done   = (i_stage.w == SIDE_W'(1)) && (i_stage.h == SIDE_W'(1));
            n_stage.w      = (i_stage.w > SIDE_W'(1)) ? (i_stage.w >> 1) : SIDE_W'(1);
            n_stage.h      = (i_stage.h > SIDE_W'(1)) ? (i_stage.h >> 1) : SIDE_W'(1);
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== src/texture_buffer_size_calc_top.sv =====
// top level of the tiled texture buffer size calculator
//
// Usage:
//   One query word comes in on the slave stream (width, height, format code,
//   mipmap flag, level count) and one result word leaves on the master stream
//   with the bytes of tiled texture memory that the texture needs.
//   The pipeline has a format decode stage, one stage per mip level (eleven,
//   enough for an 11-bit side to halve down to 1) and a final sum and
//   saturate stage; the decode register loads at the edge that takes the
//   query; from there it moves through the level and the output registers.
//   A new query enters every unstalled cycle; throughput is one word a cycle,
//   set by the eleven unrolled level stages, each with one 11x11 multiplier.
//   All stages advance together: when the receiver holds tready low with a
//   result waiting, the whole pipeline stalls and o_s_tready falls with it,
//   so nothing is lost or repeated. Reset clears the valid bits of every
//   stage; no result is pending afterwards. Totals above 0xFFFFFF saturate.
module texture_buffer_size_calc_top
    import tbsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // fields from bit 0: tex_width[10:0], tex_height[21:11], format_code[27:22],
    // mip_enable[28], level_count[36:29], zero pad[39:37]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // master stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // fields from bit 0: size_bytes[23:0]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic                    en;
    logic [SIDE_W-1:0]       in_w;
    logic [SIDE_W-1:0]       in_h;
    logic [FMT_W-1:0]        in_fmt;
    logic                    in_mip;
    logic [LEVEL_W-1:0]      in_levels;

    logic                    r_dec_valid;
    t_stage                  r_dec;
    t_stage                  n_dec;

    logic   [LEVEL_STAGES:0] lvl_valid;
    t_stage                  lvl_stage [LEVEL_STAGES+1];

    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_size;
    logic [ACC_W-1:0]        fin_total;

    // global advance: move when the output is free or being taken
    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    // unpack the query word
    assign in_w      = i_s_tdata[SIDE_W-1:0];
    assign in_h      = i_s_tdata[2*SIDE_W-1:SIDE_W];
    assign in_fmt    = i_s_tdata[2*SIDE_W+FMT_W-1:2*SIDE_W];
    assign in_mip    = i_s_tdata[2*SIDE_W+FMT_W];
    assign in_levels = i_s_tdata[IN_FIELDS_W-1:2*SIDE_W+FMT_W+1];

    // format decode; without mipmaps only the base level counts
    always_comb begin
        n_dec.w      = in_w;
        n_dec.h      = in_h;
        n_dec.tile   = tile_decode(in_fmt);
        n_dec.levels = in_mip ? in_levels : LEVEL_W'(1);
        n_dec.done   = 1'b0;
        n_dec.prod   = '0;
        n_dec.total  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (en) begin
            r_dec_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dec <= n_dec;
        end
    end

    assign lvl_valid[0] = r_dec_valid;
    assign lvl_stage[0] = r_dec;

    // one stage per mip level
    for (genvar g = 0; g < LEVEL_STAGES; g++) begin : g_level
        tbsc_level u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (lvl_valid[g]),
            .i_stage (lvl_stage[g]),
            .o_valid (lvl_valid[g+1]),
            .o_stage (lvl_stage[g+1])
        );
    end

    // add the last level and saturate
    assign fin_total = lvl_stage[LEVEL_STAGES].total
                     + tiles_to_bytes(lvl_stage[LEVEL_STAGES].prod,
                                      lvl_stage[LEVEL_STAGES].tile.tb64);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= lvl_valid[LEVEL_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_size <= (fin_total > ACC_W'(SIZE_SAT)) ? SIZE_SAT : fin_total[OUT_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_size);

endmodule

// ===== verif/texture_buffer_size_calc_top_tb.sv =====
// self-checking testbench for the tiled texture buffer size calculator
module texture_buffer_size_calc_top_tb;
    import tbsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TIME  = 30;
    localparam int MAX_REPORTS  = 10;

    // a code outside every tile group
    localparam logic [FMT_W-1:0] FMT_UNLISTED = 6'h3F;

    // one texture query
    typedef struct packed {
        logic [LEVEL_W-1:0] lvls;
        logic               mip;
        logic [FMT_W-1:0]   fmt;
        logic [SIDE_W-1:0]  h;
        logic [SIDE_W-1:0]  w;
    } t_tex_query;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_s_tvalid   = 1'b0;
    logic                   o_s_tready;
    // fields from bit 0: tex_width, tex_height, format_code, mip_enable, level_count, pad
    logic [IN_TDATA_W-1:0]  i_s_tdata    = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready   = 1'b0;
    // fields from bit 0: size_bytes
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    logic [OUT_W-1:0] pending_sizes [$];
    int unsigned      size_errs    = 0;
    int unsigned      stall_cycles = 0;
    bit               src_idle_en  = 1'b0;
    bit               sink_idle_en = 1'b0;
    bit               hold_req     = 1'b0;
    int unsigned      hold_left    = 0;

    texture_buffer_size_calc_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // bytes of one level: sides rounded up to whole tiles
    function automatic longint unsigned level_size(int unsigned w, int unsigned h,
                                                   int unsigned sx, int unsigned sy,
                                                   int unsigned tile_b);
        longint unsigned nx;
        longint unsigned ny;
        nx = (longint'(w) + (1 << sx) - 1) >> sx;
        ny = (longint'(h) + (1 << sy) - 1) >> sy;
        return nx * ny * tile_b;
    endfunction

    // expected size in bytes of one query, saturated to the output width
    function automatic logic [OUT_W-1:0] texture_bytes(t_tex_query q);
        int unsigned     sx;
        int unsigned     sy;
        int unsigned     tile_b;
        int unsigned     w;
        int unsigned     h;
        int              lv;
        longint unsigned sum;
        case (q.fmt)
            FMT_C4, FMT_C8, FMT_C14X2, FMT_CMPR, FMT_R4, FMT_Z4: begin
                sx = 3;
                sy = 3;
            end
            FMT_I8, FMT_IA4, FMT_Z8, FMT_RA4, FMT_A8,
            FMT_R8, FMT_G8, FMT_B8, FMT_Z8M, FMT_Z8L: begin
                sx = 3;
                sy = 2;
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8, FMT_Z16,
            FMT_Z24X8, FMT_RA8, FMT_RG8, FMT_GB8, FMT_Z16L: begin
                sx = 2;
                sy = 2;
            end
            default: begin
                sx = 0;
                sy = 0;
            end
        endcase
        tile_b = (q.fmt == FMT_RGBA8 || q.fmt == FMT_Z24X8) ? 64 : 32;
        w = q.w;
        h = q.h;
        sum = 0;
        if (q.mip) begin
            // halve each side down to 1, stop after the 1x1 level
            for (lv = 0; lv < int'(q.lvls); lv++) begin
                sum += level_size(w, h, sx, sy, tile_b);
                if (w == 1 && h == 1)
                    break;
                w = (w > 1) ? (w >> 1) : 1;
                h = (h > 1) ? (h >> 1) : 1;
            end
        end else begin
            sum = level_size(w, h, sx, sy, tile_b);
        end
        return (sum > longint'(SIZE_SAT)) ? SIZE_SAT : OUT_W'(sum);
    endfunction

    // reset held low at the start, then released
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // receiver: random idling plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left  <= HOLD_CYCLES;
            hold_req   <= 1'b0;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !(sink_idle_en && $urandom_range(99) < 16);
        end
    end

    // result checker; sampled between edges, the word is taken at the next edge
    always @(negedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_sizes.size() == 0) begin
                size_errs++;
                if (size_errs <= MAX_REPORTS)
                    $display("unexpected result word: size_bytes=%0d", o_m_tdata[OUT_W-1:0]);
            end else begin
                want = pending_sizes.pop_front();
                if (o_m_tdata[OUT_W-1:0] !== want) begin
                    size_errs++;
                    if (size_errs <= MAX_REPORTS)
                        $display("size_bytes mismatch: expected %0d, got %0d",
                                 want, o_m_tdata[OUT_W-1:0]);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(negedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // offer one query word and wait until it is taken
    task automatic send_query(input t_tex_query q);
        bit taken;
        while (src_idle_en && $urandom_range(99) < 16) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TDATA_W'(q);
        do begin
            @(negedge i_clk);
            taken = o_s_tready;
            if (taken)
                pending_sizes.push_back(texture_bytes(q));
            @(posedge i_clk);
        end while (!taken);
    endtask

    // sender pauses until every expected word has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_sizes.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_tex_query mk_query(int unsigned w, int unsigned h,
                                            logic [FMT_W-1:0] fmt, bit mip,
                                            int unsigned lvls);
        t_tex_query q;
        q.w    = SIDE_W'(w);
        q.h    = SIDE_W'(h);
        q.fmt  = fmt;
        q.mip  = mip;
        q.lvls = LEVEL_W'(lvls);
        return q;
    endfunction

    function automatic logic [FMT_W-1:0] rand_format();
        if ($urandom_range(99) < 20)
            return FMT_W'($urandom);
        case ($urandom_range(25))
            0:  return FMT_I8;
            1:  return FMT_IA4;
            2:  return FMT_IA8;
            3:  return FMT_RGB565;
            4:  return FMT_RGB5A3;
            5:  return FMT_RGBA8;
            6:  return FMT_C4;
            7:  return FMT_C8;
            8:  return FMT_C14X2;
            9:  return FMT_CMPR;
            10: return FMT_Z8;
            11: return FMT_Z16;
            12: return FMT_Z24X8;
            13: return FMT_R4;
            14: return FMT_RA4;
            15: return FMT_RA8;
            16: return FMT_A8;
            17: return FMT_R8;
            18: return FMT_G8;
            19: return FMT_B8;
            20: return FMT_RG8;
            21: return FMT_GB8;
            22: return FMT_Z4;
            23: return FMT_Z8M;
            24: return FMT_Z8L;
            default: return FMT_Z16L;
        endcase
    endfunction

    // mostly small sides, some up to the nominal maximum, a few over the full range
    function automatic logic [SIDE_W-1:0] rand_side();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return SIDE_W'($urandom_range(0, 64));
        else if (pick < 85)
            return SIDE_W'($urandom_range(0, 1024));
        return SIDE_W'($urandom);
    endfunction

    function automatic t_tex_query rand_query();
        t_tex_query q;
        q.w    = rand_side();
        q.h    = rand_side();
        q.fmt  = rand_format();
        q.mip  = 1'($urandom_range(1));
        q.lvls = ($urandom_range(99) < 70) ? LEVEL_W'($urandom_range(0, 12))
                                           : LEVEL_W'($urandom);
        return q;
    endfunction

    // extremes, each tile group and the special cases
    task automatic test_directed();
        send_query(mk_query(0, 0, FMT_RGBA8, 1'b0, 0));
        send_query(mk_query(0, 8, FMT_C4, 1'b1, 4));
        send_query(mk_query(64, 64, FMT_I8, 1'b1, 0));
        send_query(mk_query(2047, 2047, FMT_I4, 1'b0, 255));
        send_query(mk_query(1024, 1024, FMT_I4, 1'b1, 255));
        send_query(mk_query(1024, 1024, FMT_CMPR, 1'b1, 11));
        send_query(mk_query(1024, 1024, FMT_RGBA8, 1'b0, 1));
        send_query(mk_query(2047, 1, FMT_Z24X8, 1'b1, 255));
        send_query(mk_query(1, 1, FMT_C14X2, 1'b1, 255));
        send_query(mk_query(5, 3, FMT_I8, 1'b0, 7));
        send_query(mk_query(13, 9, FMT_RGB565, 1'b1, 8));
        send_query(mk_query(7, 7, FMT_UNLISTED, 1'b1, 3));
        send_query(mk_query(16, 16, FMT_I4, 1'b0, 0));
        send_query(mk_query(1025, 1000, FMT_Z4, 1'b1, 20));
        send_query(mk_query(8, 8, FMT_C8, 1'b1, 1));
        send_query(mk_query(1, 2047, FMT_IA8, 1'b1, 12));
        send_query(mk_query(640, 480, FMT_Z16L, 1'b1, 10));
        send_query(mk_query(3, 5, FMT_R4, 1'b0, 255));
        send_query(mk_query(1024, 1024, FMT_Z24X8, 1'b1, 11));
        send_query(mk_query(2047, 2047, FMT_RGBA8, 1'b1, 255));
        send_query(mk_query(1366, 0, FMT_Z8L, 1'b1, 3));
        drain_results();
    endtask

    // random queries with or without idling on both sides
    task automatic test_random_flow(input int unsigned count, input bit idling);
        src_idle_en  = idling;
        sink_idle_en = idling;
        repeat (count)
            send_query(rand_query());
        drain_results();
    endtask

    // receiver holds off while queries keep coming, so the input stalls
    task automatic test_output_stall();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_req    <= 1'b1;
        repeat (60)
            send_query(rand_query());
        drain_results();
    endtask

    initial begin
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        test_directed();
        test_random_flow(450, 1'b1);
        test_random_flow(300, 1'b0);
        test_output_stall();
        test_random_flow(450, 1'b1);
        // allow for the pipeline depth before closing
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (pending_sizes.size() != 0)
            size_errs++;
        if (size_errs == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
